@@ hdl/tht_pkg.sv @@
// shared constants and codes for the timed hysteresis trigger
package tht_pkg;

    // default field widths
    localparam int TIME_WIDTH_DEF   = 48;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // configuration register index
    localparam int CFG_INDEX_WIDTH = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_LOW_LEVEL    = 2'd0,
        CFG_HIGH_LEVEL   = 2'd1,
        CFG_HOLD_TIME    = 2'd2,
        CFG_BIPOLAR_MODE = 2'd3
    } cfg_index_t;

endpackage

@@ hdl/tht_cfg.sv @@
// configuration register bank: thresholds, hold time and bipolar mode
module tht_cfg #(
    parameter int TIME_WIDTH   = tht_pkg::TIME_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = tht_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write_en,
    input  logic [tht_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
    input  logic [((TIME_WIDTH > SAMPLE_WIDTH) ? TIME_WIDTH : SAMPLE_WIDTH)-1:0] cfg_data,
    output logic signed [SAMPLE_WIDTH-1:0]           low_level,
    output logic signed [SAMPLE_WIDTH-1:0]           high_level,
    output logic [TIME_WIDTH-1:0]                    hold_time_us,
    output logic                                     bipolar_mode
);

    logic signed [SAMPLE_WIDTH-1:0] low_level_reg, low_level_next;
    logic signed [SAMPLE_WIDTH-1:0] high_level_reg, high_level_next;
    logic [TIME_WIDTH-1:0]          hold_time_reg, hold_time_next;
    logic                           bipolar_reg, bipolar_next;

    // register write decode
    always_comb
    begin
        low_level_next  = low_level_reg;
        high_level_next = high_level_reg;
        hold_time_next  = hold_time_reg;
        bipolar_next    = bipolar_reg;
        if (cfg_write_en)
        begin
            unique case (tht_pkg::cfg_index_t'(cfg_index))
                tht_pkg::CFG_LOW_LEVEL:    low_level_next  = cfg_data[SAMPLE_WIDTH-1:0];
                tht_pkg::CFG_HIGH_LEVEL:   high_level_next = cfg_data[SAMPLE_WIDTH-1:0];
                tht_pkg::CFG_HOLD_TIME:    hold_time_next  = cfg_data[TIME_WIDTH-1:0];
                tht_pkg::CFG_BIPOLAR_MODE: bipolar_next    = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_level_reg  <= '0;
            high_level_reg <= '0;
            hold_time_reg  <= '0;
            bipolar_reg    <= 1'b0;
        end
        else
        begin
            low_level_reg  <= low_level_next;
            high_level_reg <= high_level_next;
            hold_time_reg  <= hold_time_next;
            bipolar_reg    <= bipolar_next;
        end
    end

    assign low_level    = low_level_reg;
    assign high_level   = high_level_reg;
    assign hold_time_us = hold_time_reg;
    assign bipolar_mode = bipolar_reg;

endmodule

@@ hdl/tht_in_reg.sv @@
// input register stage with valid/stall handshake
module tht_in_reg #(
    parameter int TIME_WIDTH   = tht_pkg::TIME_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = tht_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [TIME_WIDTH-1:0]          time_us,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                           held_valid,
    input  logic                           held_take,
    output logic [TIME_WIDTH-1:0]          held_time,
    output logic signed [SAMPLE_WIDTH-1:0] held_sample
);

    logic                           valid_reg, valid_next;
    logic [TIME_WIDTH-1:0]          time_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                           load;

    // stall while a held item is not moving on
    assign in_stall = valid_reg && !held_take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (!valid_reg || held_take)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture on transfer
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            time_reg   <= time_us;
            sample_reg <= sample;
        end
    end

    assign held_valid  = valid_reg;
    assign held_time   = time_reg;
    assign held_sample = sample_reg;

endmodule

@@ hdl/tht_eval.sv @@
// trigger state, dwell timer update and result register
module tht_eval #(
    parameter int TIME_WIDTH   = tht_pkg::TIME_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = tht_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           held_valid,
    output logic                           held_take,
    input  logic [TIME_WIDTH-1:0]          held_time,
    input  logic signed [SAMPLE_WIDTH-1:0] held_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] low_level,
    input  logic signed [SAMPLE_WIDTH-1:0] high_level,
    input  logic [TIME_WIDTH-1:0]          hold_time_us,
    input  logic                           bipolar_mode,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           trigger_on,
    output logic                           time_backwards,
    output logic [TIME_WIDTH-1:0]          dwell_time_us
);

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    logic                  on_reg, on_next;
    logic [TIME_WIDTH-1:0] timer_reg, timer_next;
    logic [TIME_WIDTH-1:0] last_time_reg, last_time_next;
    logic                  first_reg, first_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  res_on_reg;
    logic                  res_back_reg;
    logic [TIME_WIDTH-1:0] res_dwell_reg;

    logic [TIME_WIDTH-1:0]          base_time;
    logic                           backwards;
    logic [TIME_WIDTH-1:0]          elapsed;
    logic signed [SAMPLE_WIDTH-1:0] level;
    logic                           qualifies;
    logic [TIME_WIDTH:0]            sum;

    // the held item moves on when the result register is free
    assign held_take = held_valid && (!out_valid_reg || !out_stall);

    // elapsed time since the previous sample, zero on the first one and when time runs backwards
    assign base_time = first_reg ? held_time : last_time_reg;
    assign backwards = held_time < base_time;
    assign elapsed   = backwards ? '0 : held_time - base_time;

    // compared level: magnitude in bipolar mode, saturated at the most negative code
    always_comb
    begin
        level = held_sample;
        if (bipolar_mode && held_sample[SAMPLE_WIDTH-1])
        begin
            if (held_sample == SAMPLE_MIN)
            begin
                level = SAMPLE_MAX;
            end
            else
            begin
                level = -held_sample;
            end
        end
    end

    assign qualifies = on_reg ? (level <= low_level) : (level >= high_level);
    assign sum       = {1'b0, timer_reg} + {1'b0, elapsed};

    // state update for one transfer
    always_comb
    begin
        on_next        = on_reg;
        timer_next     = timer_reg;
        last_time_next = last_time_reg;
        first_next     = first_reg;
        if (held_take)
        begin
            first_next     = 1'b0;
            last_time_next = held_time;
            if (qualifies)
            begin
                if (timer_reg > hold_time_us)
                begin
                    on_next = !on_reg;
                end
                else if (sum[TIME_WIDTH])
                begin
                    timer_next = '1;
                end
                else
                begin
                    timer_next = sum[TIME_WIDTH-1:0];
                end
            end
            else
            begin
                timer_next = '0;
            end
        end
    end

    // result valid tracking
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (held_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg        <= 1'b0;
            timer_reg     <= '0;
            last_time_reg <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            on_reg        <= on_next;
            timer_reg     <= timer_next;
            last_time_reg <= last_time_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload capture
    always_ff @(posedge clk)
    begin
        if (held_take)
        begin
            res_on_reg    <= on_next;
            res_back_reg  <= backwards;
            res_dwell_reg <= timer_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign trigger_on     = res_on_reg;
    assign time_backwards = res_back_reg;
    assign dwell_time_us  = res_dwell_reg;

endmodule

@@ hdl/timed_hysteresis_trigger.sv @@
// top level: timed hysteresis trigger with dwell time
//
//   channel   direction   handshake                  payload
//   input     in          in_valid / in_stall        time_us, sample
//   result    out         out_valid / out_stall      trigger_on, time_backwards, dwell_time_us
//   config    in          cfg_write_en               cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; a result passes the input register,
// then the result register behind the combinational state update
// the state update loop (compare, subtract, saturating add) sets the cycle time
// reset clears configuration, trigger state, dwell timer and both valid flags
// a stalled result holds in its register while one more item waits in the input register
module timed_hysteresis_trigger #(
    parameter int TIME_WIDTH   = tht_pkg::TIME_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = tht_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [TIME_WIDTH-1:0]               time_us,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                trigger_on,
    output logic                                time_backwards,
    output logic [TIME_WIDTH-1:0]               dwell_time_us,
    input  logic                                cfg_write_en,
    input  logic [tht_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [((TIME_WIDTH > SAMPLE_WIDTH) ? TIME_WIDTH : SAMPLE_WIDTH)-1:0] cfg_data
);

    logic signed [SAMPLE_WIDTH-1:0] low_level;
    logic signed [SAMPLE_WIDTH-1:0] high_level;
    logic [TIME_WIDTH-1:0]          hold_time_us;
    logic                           bipolar_mode;
    logic                           held_valid;
    logic                           held_take;
    logic [TIME_WIDTH-1:0]          held_time;
    logic signed [SAMPLE_WIDTH-1:0] held_sample;

    // configuration registers
    tht_cfg #(
        .TIME_WIDTH   (TIME_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .low_level    (low_level),
        .high_level   (high_level),
        .hold_time_us (hold_time_us),
        .bipolar_mode (bipolar_mode)
    );

    // input register
    tht_in_reg #(
        .TIME_WIDTH   (TIME_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .time_us     (time_us),
        .sample      (sample),
        .held_valid  (held_valid),
        .held_take   (held_take),
        .held_time   (held_time),
        .held_sample (held_sample)
    );

    // state update and result register
    tht_eval #(
        .TIME_WIDTH   (TIME_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_eval (
        .clk            (clk),
        .rst_n          (rst_n),
        .held_valid     (held_valid),
        .held_take      (held_take),
        .held_time      (held_time),
        .held_sample    (held_sample),
        .low_level      (low_level),
        .high_level     (high_level),
        .hold_time_us   (hold_time_us),
        .bipolar_mode   (bipolar_mode),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .trigger_on     (trigger_on),
        .time_backwards (time_backwards),
        .dwell_time_us  (dwell_time_us)
    );

endmodule
